// ----- hw/rtl/masked_star_mean_blur_defines.svh -----
// Assertion macros used by the masked star mean blur engine.
`ifndef MASKED_STAR_MEAN_BLUR_DEFINES_SVH
`define MASKED_STAR_MEAN_BLUR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSMB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSMB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/msmb_pkg.sv -----
// Types, constants and helper functions for the masked star mean blur.
`timescale 1ns / 1ps
package msmb_pkg;

    localparam int CW     = 8;
    localparam int CH_W   = 8;
    localparam int DIM_W  = 9;
    localparam int DEG_W  = 4;
    localparam int NX_W   = 10;
    localparam int SUM_W  = 15;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 9;
    localparam int DIV_W  = 4;
    localparam int QDEPTH = 2;
    localparam int QCNT_W = 2;
    localparam int PIX_W  = 3 * CH_W + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = 7'd121;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLUR_DEGREE  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [DEG_W-1:0] blur_degree;
    } cfg_t;

    typedef struct packed {
        logic            op;
        logic            in_frame;
        logic [CW-1:0]   col;
        logic [CW-1:0]   row;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            mask;
    } item_t;

    function automatic logic [1:0] dir_dx(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd3, 3'd5: r = DIR_NEG;
            3'd1, 3'd6:       r = DIR_ZERO;
            default:          r = DIR_POS;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dir_dy(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd1, 3'd2: r = DIR_NEG;
            3'd3, 3'd4:       r = DIR_ZERO;
            default:          r = DIR_POS;
        endcase
        return r;
    endfunction

    // Coordinate stepped by d along one axis; negative results set the top bit.
    function automatic logic [NX_W-1:0] step_coord(input logic [CW-1:0] base,
                                                    input logic [1:0] dir,
                                                    input logic [DEG_W-1:0] d);
        logic [NX_W-1:0] r;
        case (dir)
            DIR_POS: r = {2'b00, base} + {6'b0, d};
            DIR_NEG: r = {2'b00, base} - {6'b0, d};
            default: r = {2'b00, base};
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/msmb_front.sv -----
// Front end: configuration registers, input accept and item classification.
`timescale 1ns / 1ps
module msmb_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_DEGREE = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [msmb_pkg::IDX_W-1:0]     cfg_index,
    input  logic [msmb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [msmb_pkg::CW-1:0]        col_index,
    input  logic [msmb_pkg::CW-1:0]        row_index,
    input  logic [msmb_pkg::CH_W-1:0]      in_red,
    input  logic [msmb_pkg::CH_W-1:0]      in_green,
    input  logic [msmb_pkg::CH_W-1:0]      in_blue,
    input  logic                           blur_select,
    input  logic                           q_full,
    output logic                           q_push,
    output msmb_pkg::item_t                q_item,
    output msmb_pkg::cfg_t                 cfg
);

    localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    msmb_pkg::cfg_t cfg_reg;
    logic [msmb_pkg::DIM_W-1:0] dim_v;
    logic [msmb_pkg::DIM_W-1:0] fw_next;
    logic [msmb_pkg::DIM_W-1:0] fh_next;
    logic [msmb_pkg::DEG_W-1:0] deg_next;
    logic in_frame;

    always_comb
    begin
        dim_v = (cfg_data == '0) ? msmb_pkg::DIM_W'(1) : cfg_data;
        fw_next = (32'(dim_v) > MAX_WIDTH) ? msmb_pkg::DIM_W'(MAX_WIDTH) : dim_v;
        fh_next = (32'(dim_v) > MAX_HEIGHT) ? msmb_pkg::DIM_W'(MAX_HEIGHT) : dim_v;
        deg_next = (32'(cfg_data[msmb_pkg::DEG_W-1:0]) > MAX_DEGREE)
                 ? msmb_pkg::DEG_W'(MAX_DEGREE) : cfg_data[msmb_pkg::DEG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= msmb_pkg::DIM_W'(RST_W);
            cfg_reg.frame_height <= msmb_pkg::DIM_W'(RST_H);
            cfg_reg.blur_degree  <= msmb_pkg::DEG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                msmb_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= fw_next;
                msmb_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= fh_next;
                msmb_pkg::REG_BLUR_DEGREE:  cfg_reg.blur_degree  <= deg_next;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
    assign in_stall = q_full;
    assign in_frame = ({1'b0, col_index} < cfg_reg.frame_width)
                   && ({1'b0, row_index} < cfg_reg.frame_height);

    // Writes outside the frame are dropped here.
    assign q_push = in_valid && !q_full && (opcode == msmb_pkg::OP_READ || in_frame);

    always_comb
    begin
        q_item.op       = opcode;
        q_item.in_frame = in_frame;
        q_item.col      = col_index;
        q_item.row      = row_index;
        q_item.red      = in_red;
        q_item.green    = in_green;
        q_item.blue     = in_blue;
        q_item.mask     = blur_select;
    end

endmodule

// ----- hw/rtl/msmb_fifo.sv -----
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
module msmb_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  msmb_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output msmb_pkg::item_t head_item
);

    msmb_pkg::item_t entry_reg [msmb_pkg::QDEPTH];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [msmb_pkg::QCNT_W-1:0] count_reg;

    assign full = (count_reg == msmb_pkg::QCNT_W'(msmb_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/msmb_engine.sv -----
// Back end: frame memory, star neighbor gather, serial divide, output register.
`timescale 1ns / 1ps
`include "masked_star_mean_blur_defines.svh"
module msmb_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  msmb_pkg::cfg_t            cfg,
    input  logic                      head_valid,
    input  msmb_pkg::item_t           head_item,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [msmb_pkg::CH_W-1:0] out_red,
    output logic [msmb_pkg::CH_W-1:0] out_green,
    output logic [msmb_pkg::CH_W-1:0] out_blue
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CDATA, S_GATHER, S_DRAIN, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic [msmb_pkg::PIX_W-1:0] mem [DEPTH];
    logic [msmb_pkg::PIX_W-1:0] rd_data_reg;
    logic pend_reg;
    logic [msmb_pkg::CW-1:0] x_reg;
    logic [msmb_pkg::CW-1:0] y_reg;
    logic [msmb_pkg::DEG_W-1:0] d_reg;
    logic [2:0] k_reg;
    logic [msmb_pkg::DIV_W-1:0] div_reg;
    logic [msmb_pkg::CNT_W-1:0] cnt_reg;
    logic [2:0][msmb_pkg::SUM_W-1:0] sum_reg;
    logic [2:0][msmb_pkg::SUM_W-1:0] rem_reg;
    logic out_valid_reg;
    logic [2:0][msmb_pkg::CH_W-1:0] out_reg;

    logic [msmb_pkg::NX_W-1:0] nx;
    logic [msmb_pkg::NX_W-1:0] ny;
    logic nb_in;
    logic last_nb;
    logic wr_en;
    logic rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0] wr_lin;
    logic [31:0] rd_lin;
    logic [2:0][msmb_pkg::CH_W-1:0] nb_ch;
    logic [2:0][msmb_pkg::SUM_W:0] trial;
    logic out_free;

    always_comb
    begin
        nx = msmb_pkg::step_coord(x_reg, msmb_pkg::dir_dx(k_reg), d_reg);
        ny = msmb_pkg::step_coord(y_reg, msmb_pkg::dir_dy(k_reg), d_reg);
        nb_in = !nx[msmb_pkg::NX_W-1] && !ny[msmb_pkg::NX_W-1]
             && (nx < {1'b0, cfg.frame_width}) && (ny < {1'b0, cfg.frame_height});
        last_nb = (k_reg == 3'd7) && (d_reg == cfg.blur_degree);

        wr_en = (state_reg == S_IDLE) && head_valid && (head_item.op == msmb_pkg::OP_WRITE);
        wr_lin = 32'(head_item.row) * 32'(MAX_WIDTH) + 32'(head_item.col);
        wr_addr = wr_lin[AW-1:0];

        if (state_reg == S_GATHER)
        begin
            rd_en = nb_in;
            rd_lin = 32'(ny) * 32'(MAX_WIDTH) + 32'(nx);
        end
        else
        begin
            rd_en = (state_reg == S_IDLE) && head_valid
                 && (head_item.op == msmb_pkg::OP_READ) && head_item.in_frame;
            rd_lin = 32'(head_item.row) * 32'(MAX_WIDTH) + 32'(head_item.col);
        end
        rd_addr = rd_lin[AW-1:0];

        pop = (state_reg == S_IDLE) && head_valid;

        nb_ch[0] = rd_data_reg[3*msmb_pkg::CH_W-1:2*msmb_pkg::CH_W];
        nb_ch[1] = rd_data_reg[2*msmb_pkg::CH_W-1:msmb_pkg::CH_W];
        nb_ch[2] = rd_data_reg[msmb_pkg::CH_W-1:0];

        for (int c = 0; c < 3; c++)
        begin
            trial[c] = {rem_reg[c], sum_reg[c][msmb_pkg::SUM_W-1]}
                     - {{(msmb_pkg::SUM_W-msmb_pkg::CNT_W+1){1'b0}}, cnt_reg};
        end

        out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {head_item.mask, head_item.red, head_item.green, head_item.blue};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            pend_reg <= (state_reg == S_GATHER) && nb_in;
            if (pend_reg)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sum_reg[c] <= sum_reg[c] + msmb_pkg::SUM_W'(nb_ch[c]);
                end
                cnt_reg <= cnt_reg + 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid && head_item.op == msmb_pkg::OP_READ)
                    begin
                        x_reg <= head_item.col;
                        y_reg <= head_item.row;
                        if (head_item.in_frame)
                        begin
                            state_reg <= S_CDATA;
                        end
                        else
                        begin
                            sum_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_CDATA:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_reg[c] <= msmb_pkg::SUM_W'(nb_ch[c]);
                        rem_reg[c] <= '0;
                    end
                    cnt_reg <= msmb_pkg::CNT_W'(1);
                    d_reg   <= msmb_pkg::DEG_W'(1);
                    k_reg   <= 3'd0;
                    div_reg <= '0;
                    if (rd_data_reg[msmb_pkg::PIX_W-1] && cfg.blur_degree != '0)
                    begin
                        state_reg <= S_GATHER;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_GATHER:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd7)
                    begin
                        d_reg <= d_reg + 1'b1;
                    end
                    if (last_nb)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // Restoring divide, one quotient bit per cycle.
                    for (int c = 0; c < 3; c++)
                    begin
                        if (!trial[c][msmb_pkg::SUM_W])
                        begin
                            rem_reg[c] <= trial[c][msmb_pkg::SUM_W-1:0];
                            sum_reg[c] <= {sum_reg[c][msmb_pkg::SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[c] <= {rem_reg[c][msmb_pkg::SUM_W-2:0],
                                           sum_reg[c][msmb_pkg::SUM_W-1]};
                            sum_reg[c] <= {sum_reg[c][msmb_pkg::SUM_W-2:0], 1'b0};
                        end
                    end
                    div_reg <= div_reg + 1'b1;
                    if (div_reg == msmb_pkg::DIV_W'(msmb_pkg::SUM_W - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            out_reg[c] <= sum_reg[c][msmb_pkg::CH_W-1:0];
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];

    `MSMB_ASSERT_NEXT(a_pend_from_gather, (state_reg == S_GATHER) && nb_in, pend_reg,
        "neighbor fetch lost")
    `MSMB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= msmb_pkg::CNT_MAX || state_reg == S_IDLE
        || state_reg == S_OUT || state_reg == S_CDATA, "neighbor count overflow")
    `MSMB_ASSERT_NOW(a_no_pend_in_div, state_reg == S_DIV, !pend_reg,
        "accumulate during divide")
    `MSMB_ASSERT_NOW(a_pop_only_idle, pop, state_reg == S_IDLE && head_valid,
        "queue pop outside idle")

endmodule

// ----- hw/rtl/masked_star_mean_blur.sv -----
// Top level of the masked star mean blur.
`timescale 1ns / 1ps
// Stores an RGB frame with one mask bit per pixel and answers read beats with
// the stored color or, for masked pixels, the truncated per-channel mean over
// the pixel and its in-frame star neighbors up to blur_degree. A masked read is
// paced by the single read port of the frame memory (one neighbor per cycle)
// and the 15-step serial divider; the engine takes the next beat from the queue
// only when back in idle. A two-entry queue sits between input classification
// and the execution unit.
module masked_star_mean_blur #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_DEGREE = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [msmb_pkg::IDX_W-1:0] cfg_index,
    input  logic [msmb_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       opcode,
    input  logic [msmb_pkg::CW-1:0]    col_index,
    input  logic [msmb_pkg::CW-1:0]    row_index,
    input  logic [msmb_pkg::CH_W-1:0]  in_red,
    input  logic [msmb_pkg::CH_W-1:0]  in_green,
    input  logic [msmb_pkg::CH_W-1:0]  in_blue,
    input  logic                       blur_select,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [msmb_pkg::CH_W-1:0]  out_red,
    output logic [msmb_pkg::CH_W-1:0]  out_green,
    output logic [msmb_pkg::CH_W-1:0]  out_blue
);

    msmb_pkg::cfg_t  cfg;
    msmb_pkg::item_t q_item;
    msmb_pkg::item_t head_item;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic head_valid;

    msmb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .col_index   (col_index),
        .row_index   (row_index),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .blur_select (blur_select),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_item),
        .cfg         (cfg)
    );

    msmb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    msmb_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

endmodule
